>>> hdl/assert_macros.svh
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check prop on every rising edge while reset is released.
`define ASSERT_CLK(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
	else $error("assertion failed");

// Check prop on every rising edge, reset included.
`define ASSERT_ALWAYS(lbl, clk, prop) \
	lbl: assert property (@(posedge clk) (prop)) \
	else $error("assertion failed");

`endif

>>> hdl/tts_pkg.sv
package tts_pkg;

	// Item kinds
	localparam logic KIND_TICK  = 1'b0;
	localparam logic KIND_WRITE = 1'b1;

	// Sequencer states
	typedef enum logic [4:0] {
		ST_IDLE   = 5'b00001,
		ST_SCAN   = 5'b00010,
		ST_DRAIN  = 5'b00100,
		ST_CHECK  = 5'b01000,
		ST_RELOAD = 5'b10000
	} tts_state_t;

	// Control from the sequencer to the compare unit
	typedef struct packed {
		logic en;     // present a candidate this cycle
		logic first;  // candidate opens a new search
	} scan_ctl_t;

endpackage

>>> hdl/tts_ctr_mem.sv
module tts_ctr_mem import tts_pkg::*; #(
	parameter int DEPTH = 8,
	parameter int AW    = 3,
	parameter int DW    = 4
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          wr_en,
	input  logic [AW-1:0] wr_addr,
	input  logic [DW-1:0] wr_data,
	input  logic          rd_en,
	input  logic [AW-1:0] rd_addr,
	output logic [DW-1:0] rd_data
);

	logic [DW-1:0]    mem [DEPTH];
	logic [DEPTH-1:0] vld_q;
	logic [DW-1:0]    rd_q;
	logic             rd_vld_q;

	// Entries never written read as zero.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (wr_en) begin
			vld_q[wr_addr] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_vld_q <= 1'b0;
		end else if (rd_en) begin
			rd_vld_q <= vld_q[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_vld_q ? rd_q : '0;

endmodule

>>> hdl/tts_scan_unit.sv
module tts_scan_unit import tts_pkg::*; #(
	parameter int IW = 3,
	parameter int DW = 4
) (
	input  logic          clk,
	input  scan_ctl_t     ctl,
	input  logic [IW-1:0] cand_idx,
	input  logic [DW-1:0] cand_val,
	output logic [IW-1:0] best_idx,
	output logic [DW-1:0] best_val
);

	logic [IW-1:0] best_idx_q;
	logic [DW-1:0] best_val_q;

	// Strictly greater replaces, so the lowest index keeps a tie.
	always_ff @(posedge clk) begin
		if (ctl.en && (ctl.first || (cand_val > best_val_q))) begin
			best_idx_q <= cand_idx;
			best_val_q <= cand_val;
		end
	end

	assign best_idx = best_idx_q;
	assign best_val = best_val_q;

endmodule

>>> hdl/timer_tick_task_scheduler_core.sv
// Channel | Handshake          | Beat payload
// --------+--------------------+--------------------------------------------
// in      | in_valid, in_stall | kind, task_index, priority_req
// out     | out_valid, out_stall | running_task, switched, reloaded,
//         |                    | remaining_count
//
// A priority write, or a tick that leaves the slice nonzero, answers in the
// cycle after it is taken. A tick that reschedules runs the compare unit
// over tasks 1..TASK_COUNT-1 through the counter memory read port, then
// through DRAIN and CHECK; when every counter is zero, the reload sweep
// refills the counters from the priorities before CHECK runs again.
// Reset clears counters and the running task, and sets every priority to one.
// in_stall is high while an item is in work or a result beat is held by
// out_stall.
`include "assert_macros.svh"

module timer_tick_task_scheduler_core import tts_pkg::*; #(
	parameter int TASK_COUNT = 8,
	parameter int COUNT_BITS = 4
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic       kind,
	input  logic [2:0] task_index,
	input  logic [3:0] priority_req,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [2:0] running_task,
	output logic       switched,
	output logic       reloaded,
	output logic [3:0] remaining_count
);

	localparam int IW     = $clog2(TASK_COUNT);
	localparam int CW     = COUNT_BITS;
	// Only tasks 1..7 are writable through the 3-bit index; the rest keep one.
	localparam int PRIO_N = (TASK_COUNT < 8) ? TASK_COUNT : 8;
	localparam int PW     = $clog2(PRIO_N);
	localparam int QW     = (CW > 4) ? CW : 4;

	localparam logic [IW-1:0] FIRST_IDX = IW'(1);
	localparam logic [IW-1:0] LAST_IDX  = IW'(TASK_COUNT - 1);
	localparam logic [CW-1:0] COUNT_MAX = '1;
	localparam logic [CW-1:0] CNT_ONE   = CW'(1);

	tts_state_t    state_q;
	logic [IW-1:0] idx_q;
	logic [IW-1:0] idx_s1;
	logic          rd_s1;
	logic [IW-1:0] active_q;
	logic [CW-1:0] act_cnt_q;   // mirror of the running task's counter
	logic          reload_q;
	logic [CW-1:0] prio_q [PRIO_N];

	logic          out_valid_q;
	logic [2:0]    running_task_q;
	logic          switched_q;
	logic          reloaded_q;
	logic [3:0]    remaining_count_q;

	logic          acc;
	logic          is_tick;
	logic          need_sched;
	logic [CW-1:0] cnt_dec;
	logic [CW-1:0] prio_fit;
	logic [QW-1:0] prio_nz;
	logic          prio_wr;
	logic [CW-1:0] prio_rd;

	logic          mem_wr_en;
	logic [IW-1:0] mem_wr_addr;
	logic [CW-1:0] mem_wr_data;
	logic          mem_rd_en;
	logic [CW-1:0] mem_rd_data;

	scan_ctl_t     sc_ctl;
	logic [IW-1:0] sc_idx;
	logic [CW-1:0] sc_val;
	logic [IW-1:0] best_idx;
	logic [CW-1:0] best_val;
	logic          finish;

	// Input side: take a beat only when idle and the result slot is free.
	assign in_stall   = (state_q != ST_IDLE) || (out_valid_q && out_stall);
	assign acc        = in_valid && !in_stall;
	assign is_tick    = (kind == KIND_TICK);
	assign need_sched = (active_q == '0) || (act_cnt_q == '0) || (act_cnt_q == CNT_ONE);
	assign cnt_dec    = act_cnt_q - CNT_ONE;

	// Fit the requested priority into 1..COUNT_MAX.
	assign prio_nz  = (priority_req == 4'd0) ? QW'(1) : QW'(priority_req);
	assign prio_fit = (prio_nz > QW'(COUNT_MAX)) ? COUNT_MAX : CW'(prio_nz);
	assign prio_wr  = acc && !is_tick && (task_index != 3'd0)
		&& ({1'b0, task_index} < 4'(PRIO_N));

	assign prio_rd = ({1'b0, idx_q} < (IW + 1)'(PRIO_N)) ? prio_q[idx_q[PW-1:0]] : CNT_ONE;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < PRIO_N; i++) begin
				prio_q[i] <= CNT_ONE;
			end
		end else if (prio_wr) begin
			prio_q[task_index[PW-1:0]] <= prio_fit;
		end
	end

	// Counter memory: charge the slice on a tick, refill on reload.
	always_comb begin
		mem_wr_en   = 1'b0;
		mem_wr_addr = active_q;
		mem_wr_data = cnt_dec;
		if (state_q == ST_RELOAD) begin
			mem_wr_en   = 1'b1;
			mem_wr_addr = idx_q;
			mem_wr_data = prio_rd;
		end else if (acc && is_tick && (active_q != '0) && (act_cnt_q != '0)) begin
			mem_wr_en = 1'b1;
		end
	end

	assign mem_rd_en = (state_q == ST_SCAN);

	tts_ctr_mem #(
		.DEPTH (TASK_COUNT),
		.AW    (IW),
		.DW    (CW)
	) u_ctr_mem (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (mem_wr_en),
		.wr_addr (mem_wr_addr),
		.wr_data (mem_wr_data),
		.rd_en   (mem_rd_en),
		.rd_addr (idx_q),
		.rd_data (mem_rd_data)
	);

	// Feed the compare unit from the memory read during a scan, and
	// from the priorities during the reload sweep.
	always_comb begin
		sc_ctl.en    = 1'b0;
		sc_ctl.first = 1'b0;
		sc_idx       = idx_s1;
		sc_val       = mem_rd_data;
		if (state_q == ST_RELOAD) begin
			sc_ctl.en    = 1'b1;
			sc_ctl.first = (idx_q == FIRST_IDX);
			sc_idx       = idx_q;
			sc_val       = prio_rd;
		end else if (rd_s1) begin
			sc_ctl.en    = 1'b1;
			sc_ctl.first = (idx_s1 == FIRST_IDX);
		end
	end

	tts_scan_unit #(
		.IW (IW),
		.DW (CW)
	) u_scan (
		.clk      (clk),
		.ctl      (sc_ctl),
		.cand_idx (sc_idx),
		.cand_val (sc_val),
		.best_idx (best_idx),
		.best_val (best_val)
	);

	assign finish = (state_q == ST_CHECK) && !((best_val == '0) && !reload_q);

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			idx_q     <= FIRST_IDX;
			idx_s1    <= FIRST_IDX;
			rd_s1     <= 1'b0;
			active_q  <= '0;
			act_cnt_q <= '0;
			reload_q  <= 1'b0;
		end else begin
			rd_s1  <= (state_q == ST_SCAN);
			idx_s1 <= idx_q;
			case (state_q)
				ST_IDLE: begin
					if (acc && is_tick) begin
						reload_q <= 1'b0;
						if ((active_q != '0) && (act_cnt_q != '0)) begin
							act_cnt_q <= cnt_dec;
						end
						if (need_sched) begin
							idx_q   <= FIRST_IDX;
							state_q <= ST_SCAN;
						end
					end
				end
				ST_SCAN: begin
					idx_q <= IW'(idx_q + FIRST_IDX);
					if (idx_q == LAST_IDX) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					state_q <= ST_CHECK;
				end
				ST_CHECK: begin
					if (finish) begin
						active_q  <= best_idx;
						act_cnt_q <= best_val;
						state_q   <= ST_IDLE;
					end else begin
						// every slice used up: refill from priorities
						reload_q <= 1'b1;
						idx_q    <= FIRST_IDX;
						state_q  <= ST_RELOAD;
					end
				end
				ST_RELOAD: begin
					idx_q <= IW'(idx_q + FIRST_IDX);
					if (idx_q == LAST_IDX) begin
						state_q <= ST_CHECK;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Result register: hold the beat until out_stall drops.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (finish || (acc && !(is_tick && need_sched))) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (finish) begin
			running_task_q    <= 3'(best_idx);
			switched_q        <= (best_idx != active_q);
			reloaded_q        <= reload_q;
			remaining_count_q <= 4'(best_val);
		end else if (acc && !(is_tick && need_sched)) begin
			running_task_q    <= 3'(active_q);
			switched_q        <= 1'b0;
			reloaded_q        <= 1'b0;
			remaining_count_q <= is_tick ? 4'(cnt_dec) : 4'(act_cnt_q);
		end
	end

	assign out_valid       = out_valid_q;
	assign running_task    = running_task_q;
	assign switched        = switched_q;
	assign reloaded        = reloaded_q;
	assign remaining_count = remaining_count_q;

	// A priority write answers on the next edge.
	`ASSERT_CLK(a_write_answers, clk, arst_n, (acc && (kind == KIND_WRITE)) |=> out_valid_q)
	// Once a task has been picked the idle task never runs again.
	`ASSERT_CLK(a_no_idle_return, clk, arst_n, ($past(active_q) != '0) |-> (active_q != '0))
	// The refill sweep runs only with the reload mark set.
	`ASSERT_ALWAYS(a_reload_marked, clk, (state_q == ST_RELOAD) |-> reload_q)

endmodule

>>> dv/timer_tick_task_scheduler_core_tb.sv
module timer_tick_task_scheduler_core_tb import tts_pkg::*;;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int NTASK      = 8;
	localparam int RAND_ITEMS = 1750;
	localparam int DIR_ROWS   = 24;
	// leave headroom past the slowest rescheduling tick, one with a reload sweep
	localparam int DRAIN_CYCLES = 40;

	// One result beat as the block reports it
	typedef struct packed {
		logic [2:0] run_id;
		logic       sw;
		logic       rl;
		logic [3:0] slice;
	} sched_result_t;

	// One directed row: the input beat, and a typed-in result where one is known
	typedef struct packed {
		logic          k;
		logic [2:0]    ix;
		logic [3:0]    pr;
		logic          typed;
		sched_result_t res;
	} stim_row_t;

	// Directed walk from reset. Typed rows are the obvious ones: a write to the
	// idle task right after reset, the first tick reloading every slice to one,
	// and writes that leave task 1 running with one unit left.
	localparam stim_row_t DIR_TAB [DIR_ROWS] = '{
		'{KIND_WRITE, 3'd0, 4'd5,  1'b1, '{3'd0, 1'b0, 1'b0, 4'd0}},
		'{KIND_TICK,  3'd0, 4'd0,  1'b1, '{3'd1, 1'b1, 1'b1, 4'd1}},
		'{KIND_WRITE, 3'd7, 4'd15, 1'b1, '{3'd1, 1'b0, 1'b0, 4'd1}},
		'{KIND_WRITE, 3'd1, 4'd0,  1'b1, '{3'd1, 1'b0, 1'b0, 4'd1}},
		'{KIND_WRITE, 3'd3, 4'd15, 1'b0, '0},
		'{KIND_TICK,  3'd7, 4'd15, 1'b0, '0},
		'{KIND_TICK,  3'd0, 4'd0,  1'b0, '0},
		'{KIND_TICK,  3'd0, 4'd0,  1'b0, '0},
		'{KIND_TICK,  3'd0, 4'd0,  1'b0, '0},
		'{KIND_TICK,  3'd0, 4'd0,  1'b0, '0},
		'{KIND_TICK,  3'd0, 4'd0,  1'b0, '0},
		'{KIND_TICK,  3'd0, 4'd0,  1'b0, '0},
		'{KIND_TICK,  3'd0, 4'd0,  1'b0, '0},
		'{KIND_WRITE, 3'd7, 4'd1,  1'b0, '0},
		'{KIND_WRITE, 3'd2, 4'd8,  1'b0, '0},
		'{KIND_WRITE, 3'd0, 4'd0,  1'b0, '0},
		'{KIND_WRITE, 3'd4, 4'd0,  1'b0, '0},
		'{KIND_TICK,  3'd0, 4'd0,  1'b0, '0},
		'{KIND_TICK,  3'd0, 4'd0,  1'b0, '0},
		'{KIND_WRITE, 3'd5, 4'd15, 1'b0, '0},
		'{KIND_TICK,  3'd0, 4'd0,  1'b0, '0},
		'{KIND_TICK,  3'd0, 4'd0,  1'b0, '0},
		'{KIND_WRITE, 3'd6, 4'd1,  1'b0, '0},
		'{KIND_TICK,  3'd0, 4'd0,  1'b0, '0}
	};

	// DUT ports, inputs all known from time zero
	logic       clk          = 1'b0;
	logic       arst_n       = 1'b0;
	logic       in_valid     = 1'b0;
	logic       in_stall;
	logic       kind         = 1'b0;
	logic [2:0] task_index   = 3'd0;
	logic [3:0] priority_req = 4'd0;
	logic       out_valid;
	logic       out_stall    = 1'b0;
	logic [2:0] running_task;
	logic       switched;
	logic       reloaded;
	logic [3:0] remaining_count;

	// Scheduler mirror: slices, priorities and the running task
	logic [3:0] slice_cnt [NTASK];
	logic [3:0] prio_tab  [NTASK];
	logic [2:0] cur_task;

	sched_result_t sched_q [$];   // results still owed by the block
	int            err_count = 0;
	bit            calm      = 1'b0;  // suppress idling on both sides

	timer_tick_task_scheduler_core #(
		.TASK_COUNT(NTASK),
		.COUNT_BITS(4)
	) u_dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.kind            (kind),
		.task_index      (task_index),
		.priority_req    (priority_req),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.running_task    (running_task),
		.switched        (switched),
		.reloaded        (reloaded),
		.remaining_count (remaining_count)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	// Hard stop in case the block hangs
	initial begin
		#5_000_000;
		$display("tb: failure");
		$finish;
	end

	// Largest slice among tasks 1..NTASK-1, lowest index on ties
	function automatic logic [2:0] best_task(output logic [3:0] best_cnt);
		logic [2:0] best;
		best     = 3'd1;
		best_cnt = slice_cnt[1];
		for (int i = 2; i < NTASK; i++) begin
			if (slice_cnt[i] > best_cnt) begin
				best_cnt = slice_cnt[i];
				best     = 3'(i);
			end
		end
		return best;
	endfunction

	// Apply one beat to the mirror and return the result it must produce
	function automatic sched_result_t advance_sched(input logic k, input logic [2:0] ix,
			input logic [3:0] pr);
		sched_result_t r;
		logic [2:0]    prev;
		logic [3:0]    top;
		logic          rl;
		logic          resched;
		prev    = cur_task;
		rl      = 1'b0;
		resched = 1'b0;
		if (k == KIND_WRITE) begin
			// drop writes to the idle task; a zero priority counts as one
			// (the upper clamp is a no-op at four bits)
			if (ix != 3'd0)
				prio_tab[ix] = (pr == 4'd0) ? 4'd1 : pr;
		end else if (cur_task == 3'd0 || slice_cnt[cur_task] == 4'd0) begin
			resched = 1'b1;
		end else begin
			slice_cnt[cur_task] = slice_cnt[cur_task] - 4'd1;
			resched = (slice_cnt[cur_task] == 4'd0);
		end
		if (resched) begin
			cur_task = best_task(top);
			if (top == 4'd0) begin
				// every slice spent: refill from priorities and pick again
				for (int i = 1; i < NTASK; i++)
					slice_cnt[i] = prio_tab[i];
				rl       = 1'b1;
				cur_task = best_task(top);
			end
		end
		r.run_id = cur_task;
		r.sw     = (cur_task != prev);
		r.rl     = rl;
		r.slice  = slice_cnt[cur_task];
		return r;
	endfunction

	// Offer one beat, starting at a falling edge; return at the falling edge
	// after it is taken. Valid is left high so the next beat can follow at once.
	task automatic send_beat(input logic k, input logic [2:0] ix, input logic [3:0] pr,
			input logic typed, input sched_result_t typed_res);
		sched_result_t pred;
		while (!calm && $urandom_range(0, 99) < 13) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid     <= 1'b1;
		kind         <= k;
		task_index   <= ix;
		priority_req <= pr;
		// hold the beat until the block takes it
		do @(posedge clk); while (in_stall);
		pred = advance_sched(k, ix, pr);
		sched_q.push_back(typed ? typed_res : pred);
		@(negedge clk);
	endtask

	// Receiver: stall at random, drop idling during the calm stretch
	always @(negedge clk) begin
		out_stall <= !calm && ($urandom_range(0, 99) < 13);
	end

	// Check every accepted result beat against the oldest expectation
	always @(posedge clk) begin
		sched_result_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (sched_q.size() == 0) begin
				err_count++;
				if (err_count <= 10)
					$display("tb: unexpected result run %0d sw %0b rl %0b slice %0d",
						running_task, switched, reloaded, remaining_count);
			end else begin
				want = sched_q.pop_front();
				if (running_task !== want.run_id || switched !== want.sw ||
						reloaded !== want.rl || remaining_count !== want.slice) begin
					err_count++;
					if (err_count <= 10)
						$display("tb: mismatch exp run %0d sw %0b rl %0b slice %0d,",
							want.run_id, want.sw, want.rl, want.slice,
							" got run %0d sw %0b rl %0b slice %0d",
							running_task, switched, reloaded, remaining_count);
				end
			end
		end
	end

	initial begin
		logic       k;
		logic [2:0] ix;
		logic [3:0] pr;
		int         roll;

		// mirror starts in the reset state
		for (int i = 0; i < NTASK; i++) begin
			slice_cnt[i] = 4'd0;
			prio_tab[i]  = 4'd1;
		end
		cur_task = 3'd0;

		// hold reset, then release it at a falling edge
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed walk
		for (int r = 0; r < DIR_ROWS; r++)
			send_beat(DIR_TAB[r].k, DIR_TAB[r].ix, DIR_TAB[r].pr,
				DIR_TAB[r].typed, DIR_TAB[r].res);

		// random traffic: mostly ticks, with priority writes mixed in
		for (int n = 0; n < RAND_ITEMS; n++) begin
			if (n == 400 || n == 1300) begin
				// pause the sender until every owed result is out
				in_valid <= 1'b0;
				do @(negedge clk); while (sched_q.size() != 0);
			end
			calm = (n >= 700 && n < 1000);
			roll = $urandom_range(0, 99);
			k    = (roll < 62) ? KIND_TICK : KIND_WRITE;
			ix   = 3'($urandom_range(0, 7));
			// favor small priorities now and then so refills come often
			pr   = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(0, 2))
				: 4'($urandom_range(0, 15));
			send_beat(k, ix, pr, 1'b0, '0);
		end
		calm = 1'b0;
		in_valid <= 1'b0;

		// drain what is owed, then watch for stray beats a while longer
		while (sched_q.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (err_count == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
